>>> design/bpms_pkg.sv
package bpms_pkg;

    localparam int MAX_AXES    = 10;
    localparam int FRAC_BITS   = 16;
    localparam int AXIS_W      = 4;
    localparam int VAL_W       = 32;
    localparam int SIZE_W      = 31;
    localparam int HALF_W      = SIZE_W - 1;
    localparam int FRIC_W      = 16;
    localparam int FX_ONE      = 1 << FRAC_BITS;
    localparam int NINE_TENTHS = (9 * FX_ONE + 5) / 10;
    localparam int VIC_SAT     = (FX_ONE + 9) / 10;
    localparam int VIC_W       = FRAC_BITS + 1;
    localparam int PROD_W      = 50;
    localparam int FRICT_W     = 34;
    localparam int SUM_W       = 36;
    localparam int DIV_NW      = 50;
    localparam int DIV_DW      = 32;
    localparam int DIV_CW      = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] MODE_STEP  = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] BND_NONE   = 3'd0;
    localparam logic [2:0] BND_CLIP   = 3'd1;
    localparam logic [2:0] BND_WRAP   = 3'd2;
    localparam logic [2:0] BND_BOUNCE = 3'd3;
    localparam logic [2:0] BND_REPEL  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FRICTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_OTHER = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_MULF, ST_FRICT, ST_D1S, ST_D1W, ST_MULR,
        ST_D2S, ST_D2W, ST_SUM, ST_BND, ST_D3S, ST_D3W, ST_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [AXIS_W-1:0]       axis;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [AXIS_W-1:0]       out_axis;
        logic signed [VAL_W-1:0] position;
        logic                    last_axis;
        logic                    bad_axis;
    } out_item_t;

    typedef struct packed {
        logic [FRIC_W-1:0]          friction;
        logic [AXIS_W-1:0]          axis_count;
        logic [2:0]                 boundary_mode;
        logic [3:0][SIZE_W-1:0]     size;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (x < lo)
        begin
            return 32'sh80000000;
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

>>> design/bpms_div.sv
module bpms_div
    import bpms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              busy,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder
);

    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW:0]   shifted;

    // restoring divider: one quotient bit per cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg, quo_reg[DIV_NW-1]};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = DIV_CW'(DIV_NW);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_DW'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> design/bpms_regs.sv
module bpms_regs
    import bpms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output cfg_t                 cfg,
    output logic                 clear
);

    cfg_t cfg_reg, cfg_next;
    logic [AXIS_W-1:0] cnt_w;

    always_comb
    begin
        cfg_next = cfg_reg;
        clear    = 1'b0;
        cnt_w    = cfg_data[AXIS_W-1:0];
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRICTION:
                begin
                    if (cfg_data[FRIC_W-1:0] != '0)
                        cfg_next.friction = cfg_data[FRIC_W-1:0];
                end
                REG_AXIS_COUNT:
                begin
                    clear = 1'b1;
                    if (cnt_w == '0)
                        cfg_next.axis_count = AXIS_W'(1);
                    else if (cnt_w > AXIS_W'(MAX_AXES))
                        cfg_next.axis_count = AXIS_W'(MAX_AXES);
                    else
                        cfg_next.axis_count = cnt_w;
                end
                REG_BOUNDARY:
                begin
                    if (cfg_data[2:0] <= BND_REPEL)
                        cfg_next.boundary_mode = cfg_data[2:0];
                end
                REG_SIZE0, REG_SIZE1, REG_SIZE2, REG_SIZE_OTHER:
                begin
                    if (cfg_data != '0)
                        cfg_next.size[2'(cfg_index - REG_SIZE0)] = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.friction      <= FRIC_W'(6554);
            cfg_reg.axis_count    <= AXIS_W'(3);
            cfg_reg.boundary_mode <= BND_NONE;
            cfg_reg.size          <= {4{SIZE_W'(2621440)}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/bounded_point_mass_step_unit.sv
// Channel | Direction | Handshake          | Payload
// in      | into      | in_valid, in_stall  | in_item  (mode, axis, value)
// out     | out of    | out_valid, out_stall| out_item (out_axis, position, last_axis, bad_axis)
// cfg     | into      | cfg_wr_en           | cfg_index, cfg_data
//
// An item goes from acceptance through load, friction multiply, friction, sum, boundary and
// finish steps (a bad axis goes from load straight to finish), plus a start and a wait step
// for each pass through the shared serial divider: repel makes two passes (ratio and push)
// plus one multiply step; wrap and bounce make one (bounce only when the sum reaches a wall),
// others none. The divider is a 50-bit restoring divider, one quotient bit per cycle.
// Reset clears configuration to defaults and all stored positions and velocities.
// in_stall is high while an item is at work; a waiting result sits in the output register
// and holds the finish step until it leaves.
module bounded_point_mass_step_unit
    import bpms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    cfg_t     cfg;
    logic     clear;
    div_req_t req;
    logic     div_busy;
    logic [DIV_NW-1:0] div_q;
    logic [DIV_DW-1:0] div_r;

    bpms_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clear     (clear)
    );

    bpms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    state_t state_reg, state_next;

    // per-axis state
    logic signed [VAL_W-1:0] pos_mem_reg [MAX_AXES];
    logic signed [VAL_W-1:0] vel_mem_reg [MAX_AXES];

    // item working registers
    logic [1:0]                mode_reg, mode_next;
    logic [AXIS_W-1:0]         axis_reg, axis_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;
    logic                      bad_reg, bad_next;
    logic [HALF_W-1:0]         h_reg, h_next;
    logic signed [VAL_W-1:0]   p_reg, p_next;
    logic signed [VAL_W-1:0]   v_reg, v_next;
    logic signed [VAL_W-1:0]   force_reg, force_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [FRICT_W-1:0] fric_reg, fric_next;
    logic [VIC_W-1:0]          vic_reg, vic_next;
    logic signed [VAL_W-1:0]   rep_reg, rep_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [VAL_W-1:0]   pos_reg, pos_next;
    logic signed [VAL_W-1:0]   vel_reg, vel_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    // combinational helpers
    logic [SIZE_W-1:0]         sel_size;
    logic [HALF_W-1:0]         h_cur;
    logic signed [VAL_W:0]     h_s;
    logic [VAL_W-1:0]          p_mag;
    logic [PROD_W-1:0]         prod_mag;
    logic [DIV_NW-1:0]         d_excess;
    logic signed [SUM_W:0]     wrap_x;
    logic [SUM_W:0]            wrap_mag;
    logic [DIV_DW-1:0]         per;
    logic [DIV_DW-1:0]         m_val;
    logic signed [SUM_W-1:0]   vel_raw;
    logic signed [SUM_W-1:0]   clip_v;
    logic signed [DIV_NW:0]    rep_raw;
    logic                      accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        // pick the room size of the axis at hand; half of it, never below one lsb
        sel_size = (axis_reg < AXIS_W'(3)) ? cfg.size[axis_reg[1:0]] : cfg.size[3];
        h_cur    = (sel_size[SIZE_W-1:1] == '0) ? HALF_W'(1) : sel_size[SIZE_W-1:1];
        h_s      = $signed({3'b000, h_reg});
        p_mag    = p_reg[VAL_W-1] ? VAL_W'(-p_reg) : p_reg;
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        d_excess = div_q - DIV_NW'(NINE_TENTHS);
        wrap_x   = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(h_s);
        wrap_mag = wrap_x[SUM_W] ? (SUM_W+1)'(-wrap_x) : wrap_x;
        per      = (cfg.boundary_mode == BND_BOUNCE) ? {h_reg, 2'b00} : {1'b0, h_reg, 1'b0};
        vel_raw  = sum_reg - SUM_W'(p_reg);
        rep_raw  = prod_reg[PROD_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        if (sum_reg > SUM_W'(h_s))
            clip_v = SUM_W'(h_s);
        else if (sum_reg < -SUM_W'(h_s))
            clip_v = -SUM_W'(h_s);
        else
            clip_v = sum_reg;
        // fold a negative remainder back into range
        if (wrap_x[SUM_W] && div_r != '0)
            m_val = per - div_r;
        else
            m_val = div_r;
        if (cfg.boundary_mode == BND_BOUNCE && m_val > {1'b0, h_reg, 1'b0})
            m_val = per - m_val;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        axis_next      = axis_reg;
        val_next       = val_reg;
        bad_next       = bad_reg;
        h_next         = h_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        force_next     = force_reg;
        prod_next      = prod_reg;
        fric_next      = fric_reg;
        vic_next       = vic_reg;
        rep_next       = rep_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        req.start      = 1'b0;
        req.dividend   = '0;
        req.divisor    = {2'b00, h_reg};

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_item.mode;
                    axis_next  = in_item.axis;
                    val_next   = in_item.value;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                h_next     = h_cur;
                bad_next   = (axis_reg >= cfg.axis_count);
                rep_next   = '0;
                force_next = (mode_reg == MODE_STEP) ? val_reg : '0;
                if (mode_reg == MODE_SET)
                begin
                    // clamp the new position to the walls, start at rest
                    if (val_reg > VAL_W'($signed({2'b00, h_cur})))
                        p_next = VAL_W'($signed({2'b00, h_cur}));
                    else if (val_reg < -VAL_W'($signed({2'b00, h_cur})))
                        p_next = -VAL_W'($signed({2'b00, h_cur}));
                    else
                        p_next = val_reg;
                    v_next = '0;
                end
                else if (mode_reg == MODE_CLEAR)
                begin
                    p_next = '0;
                    v_next = '0;
                end
                else
                begin
                    p_next = pos_mem_reg[axis_reg];
                    v_next = vel_mem_reg[axis_reg];
                end
                if (axis_reg >= cfg.axis_count)
                begin
                    pos_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_MULF;
                end
            end
            ST_MULF:
            begin
                prod_next = PROD_W'($signed({2'b00, 17'(17'h10000 - {1'b0, cfg.friction})})
                                    * v_reg);
                state_next = ST_FRICT;
            end
            ST_FRICT:
            begin
                // divide by 2^16, truncating toward zero
                fric_next = FRICT_W'((prod_reg + (prod_reg[PROD_W-1] ?
                                       PROD_W'(65535) : PROD_W'(0))) >>> 16);
                state_next = (cfg.boundary_mode == BND_REPEL) ? ST_D1S : ST_SUM;
            end
            ST_D1S:
            begin
                req.start    = 1'b1;
                req.dividend = DIV_NW'({p_mag, FRAC_BITS'(0)});
                state_next   = ST_D1W;
            end
            ST_D1W:
            begin
                if (!div_busy)
                begin
                    if (div_q <= DIV_NW'(NINE_TENTHS))
                        vic_next = '0;
                    else if (d_excess >= DIV_NW'(VIC_SAT))
                        vic_next = VIC_W'(FX_ONE);
                    else
                        vic_next = VIC_W'(d_excess * 10);
                    state_next = ST_MULR;
                end
            end
            ST_MULR:
            begin
                prod_next  = PROD_W'($signed({1'b0, vic_reg}) * p_reg);
                state_next = ST_D2S;
            end
            ST_D2S:
            begin
                req.start    = 1'b1;
                req.dividend = prod_mag;
                state_next   = ST_D2W;
            end
            ST_D2W:
            begin
                if (!div_busy)
                begin
                    rep_next   = sat32(64'(rep_raw));
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next = SUM_W'(p_reg) + SUM_W'(fric_reg) + SUM_W'(force_reg)
                           - SUM_W'(rep_reg);
                state_next = ST_BND;
            end
            ST_BND:
            begin
                pos_next   = sat32(64'(sum_reg));
                vel_next   = sat32(64'(vel_raw));
                state_next = ST_FIN;
                case (cfg.boundary_mode)
                    BND_CLIP, BND_REPEL:
                    begin
                        pos_next = VAL_W'(clip_v);
                        vel_next = sat32(64'(clip_v - SUM_W'(p_reg)));
                    end
                    BND_WRAP:
                    begin
                        state_next = ST_D3S;
                    end
                    BND_BOUNCE:
                    begin
                        if (sum_reg >= SUM_W'(h_s) || sum_reg <= -SUM_W'(h_s))
                            state_next = ST_D3S;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_D3S:
            begin
                req.start    = 1'b1;
                req.dividend = DIV_NW'(wrap_mag);
                req.divisor  = per;
                state_next   = ST_D3W;
            end
            ST_D3W:
            begin
                req.divisor = per;
                if (!div_busy)
                begin
                    pos_next = sat32(64'($signed({1'b0, m_val})) - 64'(h_s));
                    if (cfg.boundary_mode == BND_BOUNCE)
                        vel_next = sat32(-64'(vel_raw));
                    else
                        vel_next = sat32(64'(vel_raw));
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    out_next.out_axis  = axis_reg;
                    out_next.position  = bad_reg ? '0 : pos_reg;
                    out_next.bad_axis  = bad_reg;
                    out_next.last_axis = !bad_reg && (axis_reg + 1'b1 == cfg.axis_count);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // store the new state of a good axis as its result goes into the output register; drop all on a count write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_AXES; i++)
            begin
                pos_mem_reg[i] <= '0;
                vel_mem_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < MAX_AXES; i++)
            begin
                pos_mem_reg[i] <= '0;
                vel_mem_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_FIN && state_next == ST_IDLE && !bad_reg)
        begin
            pos_mem_reg[axis_reg] <= pos_reg;
            vel_mem_reg[axis_reg] <= vel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        axis_reg  <= axis_next;
        val_reg   <= val_next;
        bad_reg   <= bad_next;
        h_reg     <= h_next;
        p_reg     <= p_next;
        v_reg     <= v_next;
        force_reg <= force_next;
        prod_reg  <= prod_next;
        fric_reg  <= fric_next;
        vic_reg   <= vic_next;
        rep_reg   <= rep_next;
        sum_reg   <= sum_next;
        pos_reg   <= pos_next;
        vel_reg   <= vel_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.bad_axis |-> out_item.position == '0 && !out_item.last_axis)
        else $error("bad axis item carries a position");

    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish step");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted item not loaded");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_busy)
        else $error("divider busy with no item at work");

endmodule
